[sv/cts_pkg.sv]
// Shared types, constants and codes for the text console engine.
`timescale 1ns / 1ps

package cts_pkg;

   // Screen geometry defaults
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // Field widths
   localparam int FUNC_W  = 3;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 8;
   localparam int INDEX_W = 11;
   localparam int POS_W   = 11;
   localparam int CELL_W  = CHAR_W + COLOR_W;

   // Stream and register port widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_PAD_W  = RSP_DATA_W - (POS_W + CHAR_W + COLOR_W + 1);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CHAR_W-1:0]  SPACE_CHAR  = 8'h20;
   localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

   // Command codes
   localparam logic [FUNC_W-1:0] FN_PUT       = 3'd0;
   localparam logic [FUNC_W-1:0] FN_NEWLINE   = 3'd1;
   localparam logic [FUNC_W-1:0] FN_BACKSPACE = 3'd2;
   localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd3;
   localparam logic [FUNC_W-1:0] FN_TAB       = 3'd4;
   localparam logic [FUNC_W-1:0] FN_READ      = 3'd5;

   // Register index (paddr bit 2)
   localparam logic REG_DEFAULT_COLOR = 1'b0;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUT,
      ST_SWEEP,
      ST_BS_RD,
      ST_BS_WR,
      ST_READ,
      ST_RESULT
   } cts_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_cmd;
      logic put_step;
      logic sweep_step;
      logic sweep_fill;
      logic bs_read;
      logic bs_write;
      logic cell_read;
      logic load_rsp;
   } cts_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [FUNC_W-1:0] req_func;
      logic [FUNC_W-1:0] cmd_func;
      logic              at_home;
      logic              put_wrap;
      logic              put_more;
      logic              more_pending;
      logic              sweep_last;
      logic              out_free;
   } cts_stat_type;

endpackage

[sv/cts_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module cts_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/cts_ctrl.sv]
// Command sequencer for the text console engine.
`timescale 1ns / 1ps

module cts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cts_pkg::cts_stat_type stat,
   output cts_pkg::cts_cmd_type  cmd
);

   cts_pkg::cts_state_type state_ff, state_in;
   logic                   accept;

   // First working state for a newly accepted command
   function automatic cts_pkg::cts_state_type dispatch(
      input logic [cts_pkg::FUNC_W-1:0] f,
      input logic                       at_home
   );
      cts_pkg::cts_state_type s;
      s = cts_pkg::ST_RESULT;
      unique case (f) inside
         cts_pkg::FN_PUT, cts_pkg::FN_NEWLINE, cts_pkg::FN_TAB: begin
            s = cts_pkg::ST_PUT;
         end
         cts_pkg::FN_BACKSPACE: begin
            s = at_home ? cts_pkg::ST_RESULT : cts_pkg::ST_BS_RD;
         end
         cts_pkg::FN_CLEAR: begin
            s = cts_pkg::ST_SWEEP;
         end
         cts_pkg::FN_READ: begin
            s = cts_pkg::ST_READ;
         end
         default: begin
            s = cts_pkg::ST_RESULT;
         end
      endcase
      return s;
   endfunction

   assign accept = req_valid & req_ready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cts_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cts_pkg::ST_INIT: begin
            if (stat.sweep_last) state_in = cts_pkg::ST_IDLE;
         end
         cts_pkg::ST_IDLE: begin
            if (accept) state_in = dispatch(stat.req_func, stat.at_home);
         end
         cts_pkg::ST_PUT: begin
            if (stat.put_wrap) begin
               state_in = cts_pkg::ST_SWEEP;
            end else if (stat.put_more) begin
               state_in = cts_pkg::ST_PUT;
            end else begin
               state_in = cts_pkg::ST_RESULT;
            end
         end
         cts_pkg::ST_SWEEP: begin
            if (stat.sweep_last) begin
               if (stat.cmd_func != cts_pkg::FN_CLEAR && stat.more_pending) begin
                  state_in = cts_pkg::ST_PUT;
               end else begin
                  state_in = cts_pkg::ST_RESULT;
               end
            end
         end
         cts_pkg::ST_BS_RD: begin
            state_in = cts_pkg::ST_BS_WR;
         end
         cts_pkg::ST_BS_WR: begin
            state_in = cts_pkg::ST_RESULT;
         end
         cts_pkg::ST_READ: begin
            state_in = cts_pkg::ST_RESULT;
         end
         cts_pkg::ST_RESULT: begin
            if (stat.out_free) begin
               state_in = accept ? dispatch(stat.req_func, stat.at_home) : cts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cts_pkg::ST_INIT;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         cts_pkg::ST_INIT: begin
            cmd.sweep_step = 1'b1;
            cmd.sweep_fill = 1'b1;
         end
         cts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         cts_pkg::ST_PUT: begin
            cmd.put_step = 1'b1;
         end
         cts_pkg::ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            cmd.sweep_fill = (stat.cmd_func == cts_pkg::FN_CLEAR);
         end
         cts_pkg::ST_BS_RD: begin
            cmd.bs_read = 1'b1;
         end
         cts_pkg::ST_BS_WR: begin
            cmd.bs_write = 1'b1;
         end
         cts_pkg::ST_READ: begin
            cmd.cell_read = 1'b1;
         end
         cts_pkg::ST_RESULT: begin
            cmd.load_rsp = stat.out_free;
            req_ready    = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.load_cmd = req_ready & req_valid;
   end

endmodule

[sv/cts_datapath.sv]
// Cursor, sweep counter, write pipeline and result register of the console engine.
`timescale 1ns / 1ps

module cts_datapath #(
   parameter int COLUMNS = cts_pkg::COLUMNS_DEF,
   parameter int ROWS    = cts_pkg::ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cts_pkg::cts_cmd_type                cmd,
   output cts_pkg::cts_stat_type               stat,
   input  logic [cts_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [cts_pkg::FUNC_W-1:0]          req_tuser,
   input  logic [cts_pkg::COLOR_W-1:0]         default_color,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [cts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                ram_wr_en,
   output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_wr_addr,
   output logic [cts_pkg::CELL_W-1:0]          ram_wr_data,
   output logic                                ram_rd_en,
   output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_rd_addr,
   input  logic [cts_pkg::CELL_W-1:0]          ram_rd_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] LAST_ROW  = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
   localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

   // Request fields
   logic [cts_pkg::FUNC_W-1:0]  req_func;
   logic [cts_pkg::CHAR_W-1:0]  req_char;
   logic [cts_pkg::COLOR_W-1:0] req_color;
   logic [cts_pkg::INDEX_W-1:0] req_index;

   // Latched command
   logic [cts_pkg::FUNC_W-1:0]  func_ff;
   logic [cts_pkg::CHAR_W-1:0]  char_ff;
   logic [cts_pkg::COLOR_W-1:0] color_ff;
   logic [cts_pkg::INDEX_W-1:0] index_ff;

   // Cursor state
   logic [AW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] col_ff, col_in;
   logic [1:0]    tab_ff, tab_in;
   logic          scrolled_ff, scrolled_in;
   logic          more_ff, more_in;
   logic [AW-1:0] sweep_ff, sweep_in;

   // Write pipeline
   logic                       wp_valid_ff, wp_valid_in;
   logic                       wp_copy_ff, wp_copy_in;
   logic [AW-1:0]              wp_addr_ff, wp_addr_in;
   logic [cts_pkg::CELL_W-1:0] wp_data_ff, wp_data_in;

   // Result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [cts_pkg::POS_W-1:0]   rsp_pos_ff;
   logic [cts_pkg::CHAR_W-1:0]  rsp_char_ff;
   logic [cts_pkg::COLOR_W-1:0] rsp_color_ff;
   logic                        rsp_scrolled_ff;

   logic                        is_put;
   logic [cts_pkg::CHAR_W-1:0]  put_char;
   logic [cts_pkg::COLOR_W-1:0] put_color;
   logic                        put_wrap;
   logic                        put_more;
   logic                        sweep_copy;
   logic                        read_hit;
   logic [cts_pkg::CELL_W-1:0]  blank_cell;

   assign req_func  = req_tuser;
   assign req_char  = req_tdata[7:0];
   assign req_color = req_tdata[15:8];
   assign req_index = req_tdata[26:16];

   // Cell written by one put step
   assign is_put     = (func_ff == cts_pkg::FN_PUT);
   assign put_char   = is_put ? char_ff : cts_pkg::SPACE_CHAR;
   assign put_color  = is_put ? color_ff : default_color;
   assign put_wrap   = (cursor_ff == LAST_CELL);
   assign blank_cell = {default_color, cts_pkg::SPACE_CHAR};

   // Another put follows this one within the same command
   always_comb begin
      case (func_ff)
         cts_pkg::FN_NEWLINE: put_more = (col_ff != LAST_COL);
         cts_pkg::FN_TAB:     put_more = (tab_ff != 2'd2);
         default:             put_more = 1'b0;
      endcase
   end

   // Scroll copies rows up until the last row, which is filled
   assign sweep_copy = ~cmd.sweep_fill & (sweep_ff < LAST_ROW);
   assign read_hit   = (func_ff == cts_pkg::FN_READ) & (32'(index_ff) < 32'(CELLS));

   // Command latch
   always_ff @(posedge clock) begin
      if (cmd.load_cmd) begin
         func_ff  <= req_func;
         char_ff  <= req_char;
         color_ff <= req_color;
         index_ff <= req_index;
      end
   end

   // Cursor, column, tab count, scroll flag
   always_comb begin
      cursor_in   = cursor_ff;
      col_in      = col_ff;
      tab_in      = tab_ff;
      scrolled_in = scrolled_ff;
      more_in     = more_ff;
      if (cmd.load_cmd) begin
         tab_in      = 2'd0;
         scrolled_in = 1'b0;
         if (req_func == cts_pkg::FN_CLEAR) begin
            cursor_in = '0;
            col_in    = '0;
         end
      end else if (cmd.put_step) begin
         cursor_in   = put_wrap ? LAST_ROW : cursor_ff + AW'(1);
         col_in      = (col_ff == LAST_COL) ? '0 : col_ff + CW'(1);
         tab_in      = tab_ff + 2'd1;
         scrolled_in = scrolled_ff | put_wrap;
         more_in     = put_more;
      end else if (cmd.bs_read) begin
         cursor_in = cursor_ff - AW'(1);
         col_in    = (col_ff == '0) ? LAST_COL : col_ff - CW'(1);
      end
   end

   // Sweep address counter, back to zero when not sweeping
   always_comb begin
      sweep_in = '0;
      if (cmd.sweep_step && sweep_ff != LAST_CELL) begin
         sweep_in = sweep_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= '0;
         col_ff      <= '0;
         tab_ff      <= 2'd0;
         scrolled_ff <= 1'b0;
         more_ff     <= 1'b0;
         sweep_ff    <= '0;
      end else begin
         cursor_ff   <= cursor_in;
         col_ff      <= col_in;
         tab_ff      <= tab_in;
         scrolled_ff <= scrolled_in;
         more_ff     <= more_in;
         sweep_ff    <= sweep_in;
      end
   end

   // RAM read port
   always_comb begin
      ram_rd_en   = (cmd.sweep_step & sweep_copy) | cmd.bs_read | cmd.cell_read;
      ram_rd_addr = sweep_ff + ROW_STEP;
      if (cmd.bs_read) begin
         ram_rd_addr = cursor_ff - AW'(1);
      end else if (cmd.cell_read) begin
         ram_rd_addr = AW'(index_ff);
      end
   end

   // Write pipeline: every RAM write is registered and lands in the cycle after it is issued
   always_comb begin
      wp_valid_in = cmd.put_step | cmd.sweep_step | cmd.bs_write;
      wp_copy_in  = cmd.sweep_step & sweep_copy;
      wp_addr_in  = cmd.sweep_step ? sweep_ff : cursor_ff;
      wp_data_in  = blank_cell;
      if (cmd.put_step) begin
         wp_data_in = {put_color, put_char};
      end else if (cmd.bs_write) begin
         wp_data_in = {ram_rd_data[cts_pkg::CELL_W-1:cts_pkg::CHAR_W], cts_pkg::SPACE_CHAR};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_valid_ff <= 1'b0;
      end else begin
         wp_valid_ff <= wp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wp_copy_ff <= wp_copy_in;
      wp_addr_ff <= wp_addr_in;
      wp_data_ff <= wp_data_in;
   end

   assign ram_wr_en   = wp_valid_ff;
   assign ram_wr_addr = wp_addr_ff;
   assign ram_wr_data = wp_copy_ff ? ram_rd_data : wp_data_ff;

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_pos_ff      <= cts_pkg::POS_W'(cursor_ff);
         rsp_char_ff     <= read_hit ? ram_rd_data[cts_pkg::CHAR_W-1:0] : '0;
         rsp_color_ff    <= read_hit ? ram_rd_data[cts_pkg::CELL_W-1:cts_pkg::CHAR_W] : '0;
         rsp_scrolled_ff <= scrolled_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{cts_pkg::RSP_PAD_W{1'b0}}, rsp_scrolled_ff, rsp_color_ff,
                        rsp_char_ff, rsp_pos_ff};

   // Status to the sequencer
   always_comb begin
      stat.req_func     = req_func;
      stat.cmd_func     = func_ff;
      stat.at_home      = (cursor_ff == '0);
      stat.put_wrap     = put_wrap;
      stat.put_more     = put_more;
      stat.more_pending = more_ff;
      stat.sweep_last   = (sweep_ff == LAST_CELL);
      stat.out_free     = ~rsp_valid_ff | rsp_tready;
   end

   // Checks
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= LAST_CELL)
      else $error("cursor beyond last cell");

   a_col_home: assert property (@(posedge clock) disable iff (reset)
      cursor_ff == '0 |-> col_ff == '0)
      else $error("column out of step with cursor");

   a_copy_source: assert property (@(posedge clock) disable iff (reset)
      wp_valid_ff && wp_copy_ff |-> $past(ram_rd_en))
      else $error("row copy without a read the cycle before");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

endmodule

[sv/text_console_cursor_scroll_top.sv]
// Top level of the text console engine: register port, sequencer, datapath and screen RAM.
`timescale 1ns / 1ps

// Text-mode console engine. Commands arrive on the req_ stream, one beat per command
// (kind in req_tuser); each command returns exactly one beat on the rsp_ stream with the
// cursor after the command, the cell read (read command only) and a scroll flag.
// The screen is a COLUMNS x ROWS store of character/attribute cells in one RAM with a
// single write port, so every cell touched is written through that port in turn.
// Put writes one cell, tab and newline write blanks (newline up to the next row start),
// backspace (not at home) reads then rewrites the cell before the cursor, read fetches
// one cell; a scroll (row copy then blank fill) and clear each sweep the whole screen.
// The result register is loaded in the last cycle; a new command is taken in that same cycle.
// At reset the block blanks the whole screen in default_color, one cell per cycle
// (COLUMNS*ROWS cells, 2000 by default), with req_tready low; the register port works
// meanwhile. If the receiver stalls, the finished result waits in the output register and
// the block holds before loading the next one; no result is dropped.
// default_color sits at byte address 0 of the csr_ port and should be written only idle.

module text_console_cursor_scroll_top #(
   parameter int COLUMNS = cts_pkg::COLUMNS_DEF,
   parameter int ROWS    = cts_pkg::ROWS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Command stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [7:0] character, [15:8] color, [26:16] cell_index
   input  logic [cts_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] func
   input  logic [cts_pkg::FUNC_W-1:0]       req_tuser,
   // Result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [10:0] cursor_position, [18:11] cell_character, [26:19] cell_color, [27] scrolled
   output logic [cts_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cts_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cts_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cts_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   logic [cts_pkg::COLOR_W-1:0] default_color_ff, default_color_in;
   logic                        csr_write;
   logic                        csr_sel_color;

   cts_pkg::cts_cmd_type  cmd;
   cts_pkg::cts_stat_type stat;

   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [cts_pkg::CELL_W-1:0] ram_wr_data;
   logic                       ram_rd_en;
   logic [AW-1:0]              ram_rd_addr;
   logic [cts_pkg::CELL_W-1:0] ram_rd_data;

   // Register port: one register, written in the access cycle
   assign csr_pready    = 1'b1;
   assign csr_write     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel_color = (csr_paddr[2] == cts_pkg::REG_DEFAULT_COLOR);

   always_comb begin
      default_color_in = default_color_ff;
      if (csr_write && csr_sel_color) begin
         default_color_in = csr_pwdata[cts_pkg::COLOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_color_ff <= cts_pkg::COLOR_RESET;
      end else begin
         default_color_ff <= default_color_in;
      end
   end

   assign csr_prdata = csr_sel_color ?
                       cts_pkg::CSR_DATA_W'(default_color_ff) : '0;

   cts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cts_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .default_color (default_color_ff),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tdata     (rsp_tdata),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   cts_ram #(
      .WIDTH (cts_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

[tb/tb_text_console_cursor_scroll_top.sv]
// Self-checking testbench for the text console engine: directed table, then random command mix.
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_top;
   import cts_pkg::*;

   localparam int COLS  = COLUMNS_DEF;
   localparam int CELLS = COLUMNS_DEF * ROWS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   // Codes 6 and 7 have no command behind them
   localparam logic [FUNC_W-1:0] FN_UNUSED_A = 3'd6;
   localparam logic [FUNC_W-1:0] FN_UNUSED_B = 3'd7;

   // paddr bit 2 selects the register; index 1 lies past the list
   localparam logic [CSR_ADDR_W-1:0] DEFAULT_COLOR_ADDR = {REG_DEFAULT_COLOR, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_REG_ADDR     = {~REG_DEFAULT_COLOR, 2'b00};

   typedef enum logic [1:0] {RX_FREE, RX_PATTERN, RX_RANDOM} rx_mode_t;

   typedef struct {
      logic [POS_W-1:0]   pos;
      logic [CHAR_W-1:0]  ch;
      logic [COLOR_W-1:0] attr;
      logic               scrolled;
   } cell_report_t;

   typedef struct packed {
      logic [FUNC_W-1:0]  fn;
      logic [CHAR_W-1:0]  ch;
      logic [COLOR_W-1:0] attr;
      logic [INDEX_W-1:0] idx;
      logic               typed;
      logic [POS_W-1:0]   want_pos;
      logic [CHAR_W-1:0]  want_ch;
      logic [COLOR_W-1:0] want_attr;
      logic               want_scr;
   } stim_row_t;

   // Directed commands; rows with typed set carry their own expected beat
   localparam int N_DIRECTED = 23;
   localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
      '{FN_READ,      8'h00, 8'h00, 11'd0,     1'b1, 11'd0,   8'h20, 8'h07, 1'b0},
      '{FN_READ,      8'h00, 8'h00, 11'd1999,  1'b1, 11'd0,   8'h20, 8'h07, 1'b0},
      '{FN_READ,      8'h00, 8'h00, 11'd2000,  1'b1, 11'd0,   8'h00, 8'h00, 1'b0},
      '{FN_READ,      8'hFF, 8'hFF, 11'd2047,  1'b1, 11'd0,   8'h00, 8'h00, 1'b0},
      '{FN_BACKSPACE, 8'h00, 8'h00, 11'd0,     1'b1, 11'd0,   8'h00, 8'h00, 1'b0},
      '{FN_PUT,       8'h41, 8'h1E, 11'd0,     1'b1, 11'd1,   8'h00, 8'h00, 1'b0},
      '{FN_READ,      8'h00, 8'h00, 11'd0,     1'b1, 11'd1,   8'h41, 8'h1E, 1'b0},
      '{FN_PUT,       8'hFF, 8'hFF, 11'h7FF,   1'b1, 11'd2,   8'h00, 8'h00, 1'b0},
      '{FN_PUT,       8'h00, 8'h00, 11'd0,     1'b1, 11'd3,   8'h00, 8'h00, 1'b0},
      '{FN_BACKSPACE, 8'h00, 8'h00, 11'd0,     1'b1, 11'd2,   8'h00, 8'h00, 1'b0},
      '{FN_READ,      8'h00, 8'h00, 11'd2,     1'b1, 11'd2,   8'h20, 8'h00, 1'b0},
      '{FN_TAB,       8'h00, 8'h00, 11'd0,     1'b1, 11'd5,   8'h00, 8'h00, 1'b0},
      '{FN_READ,      8'h00, 8'h00, 11'd4,     1'b1, 11'd5,   8'h20, 8'h07, 1'b0},
      '{FN_NEWLINE,   8'h00, 8'h00, 11'd0,     1'b1, 11'd80,  8'h00, 8'h00, 1'b0},
      '{FN_NEWLINE,   8'h00, 8'h00, 11'd0,     1'b1, 11'd160, 8'h00, 8'h00, 1'b0},
      '{FN_UNUSED_A,  8'hAA, 8'h55, 11'h555,   1'b1, 11'd160, 8'h00, 8'h00, 1'b0},
      '{FN_UNUSED_B,  8'h55, 8'hAA, 11'h2AA,   1'b1, 11'd160, 8'h00, 8'h00, 1'b0},
      '{FN_READ,      8'h00, 8'h00, 11'd1,     1'b1, 11'd160, 8'hFF, 8'hFF, 1'b0},
      '{FN_CLEAR,     8'h00, 8'h00, 11'd0,     1'b1, 11'd0,   8'h00, 8'h00, 1'b0},
      '{FN_READ,      8'h00, 8'h00, 11'd1,     1'b1, 11'd0,   8'h20, 8'h07, 1'b0},
      '{FN_PUT,       8'h7E, 8'h70, 11'd0,     1'b0, 11'd0,   8'h00, 8'h00, 1'b0},
      '{FN_TAB,       8'h00, 8'h00, 11'd0,     1'b0, 11'd0,   8'h00, 8'h00, 1'b0},
      '{FN_READ,      8'h00, 8'h00, 11'd0,     1'b0, 11'd0,   8'h00, 8'h00, 1'b0}
   };

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata   = '0;
   logic [FUNC_W-1:0]       req_tuser   = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   // Shadow of the screen, cursor and fill color
   logic [CELL_W-1:0]  screen_shadow [CELLS];
   int unsigned        cursor_shadow;
   logic [COLOR_W-1:0] fill_color;

   cell_report_t pending_reports [$];
   int           mismatches  = 0;
   int           quiet_cycles = 0;
   int           burst_left  = 0;

   text_console_cursor_scroll_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------- screen shadow ----------------

   function automatic void blank_screen();
      int i;
      for (i = 0; i < CELLS; i++) screen_shadow[i] = {fill_color, SPACE_CHAR};
      cursor_shadow = 0;
   endfunction

   function automatic void scroll_screen();
      int i;
      for (i = 0; i < CELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
      for (i = CELLS - COLS; i < CELLS; i++) screen_shadow[i] = {fill_color, SPACE_CHAR};
      cursor_shadow = (cursor_shadow >= COLS) ? cursor_shadow - COLS : 0;
   endfunction

   // Write at the cursor and advance; returns 1 when the screen scrolled
   function automatic bit put_cell(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] attr);
      if (cursor_shadow >= CELLS) cursor_shadow = CELLS - 1;
      screen_shadow[cursor_shadow] = {attr, ch};
      cursor_shadow++;
      if (cursor_shadow >= CELLS) begin
         scroll_screen();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic cell_report_t run_console_cmd(logic [FUNC_W-1:0] fn,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [COLOR_W-1:0] attr,
                                                    logic [INDEX_W-1:0] idx);
      cell_report_t r;
      int k;
      r.ch       = '0;
      r.attr     = '0;
      r.scrolled = 1'b0;
      case (fn)
         FN_PUT: r.scrolled = put_cell(ch, attr);
         FN_NEWLINE: begin
            do begin
               if (put_cell(SPACE_CHAR, fill_color)) r.scrolled = 1'b1;
            end while (cursor_shadow % COLS != 0);
         end
         FN_BACKSPACE: begin
            if (cursor_shadow >= 1 && cursor_shadow < CELLS) begin
               cursor_shadow--;
               screen_shadow[cursor_shadow][CHAR_W-1:0] = SPACE_CHAR;
            end
         end
         FN_CLEAR: blank_screen();
         FN_TAB: begin
            for (k = 0; k < 3; k++)
               if (put_cell(SPACE_CHAR, fill_color)) r.scrolled = 1'b1;
         end
         FN_READ: begin
            if (idx < CELLS) begin
               r.ch   = screen_shadow[idx][CHAR_W-1:0];
               r.attr = screen_shadow[idx][CELL_W-1:CHAR_W];
            end
         end
         default: ;
      endcase
      r.pos = POS_W'(cursor_shadow);
      return r;
   endfunction

   // ---------------- drivers ----------------

   // One command beat; the sender sometimes idles between bursts of random length
   task automatic issue_cmd(input logic [FUNC_W-1:0] fn, input logic [CHAR_W-1:0] ch,
                            input logic [COLOR_W-1:0] attr, input logic [INDEX_W-1:0] idx,
                            input bit typed, input cell_report_t typed_want);
      cell_report_t want;
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {{(REQ_DATA_W - INDEX_W - COLOR_W - CHAR_W){1'b0}}, idx, attr, ch};
      do @(posedge clock); while (req_tready !== 1'b1);
      want = run_console_cmd(fn, ch, attr, idx);
      if (typed) want = typed_want;
      pending_reports.push_back(want);
   endtask

   // Drop valid and wait until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [COLOR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {{(CSR_DATA_W - COLOR_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == DEFAULT_COLOR_ADDR) fill_color = value;
      @(posedge clock);
   endtask

   // Idle the block, poke the unmapped slot, then set the fill color
   task automatic set_fill_color(input logic [COLOR_W-1:0] value);
      drain_results();
      csr_write(SPARE_REG_ADDR, 8'($urandom));
      csr_write(DEFAULT_COLOR_ADDR, value);
   endtask

   function automatic logic [INDEX_W-1:0] pick_read_index();
      int unsigned lo, hi;
      case ($urandom_range(0, 3))
         0: return INDEX_W'($urandom_range(0, 2047));
         1: return INDEX_W'($urandom_range(CELLS - COLS, 2047));
         default: begin
            lo = (cursor_shadow > COLS) ? cursor_shadow - COLS : 0;
            hi = (cursor_shadow + COLS > 2047) ? 2047 : cursor_shadow + COLS;
            return INDEX_W'($urandom_range(lo, hi));
         end
      endcase
   endfunction

   // Mostly text and line feeds so the screen fills and scrolls; clears are rare
   task automatic random_phase(input int count);
      cell_report_t none;
      logic [FUNC_W-1:0] fn;
      logic [INDEX_W-1:0] idx;
      int pick, sent, run;
      none = '{default: '0};
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 199);
         idx  = INDEX_W'($urandom_range(0, 2047));
         run  = 1;
         if (pick == 0) fn = FN_CLEAR;
         else if (pick < 16) begin
            fn  = FN_NEWLINE;
            run = $urandom_range(4, 14);
         end
         else if (pick < 100) fn = FN_PUT;
         else if (pick < 130) fn = FN_NEWLINE;
         else if (pick < 144) fn = FN_TAB;
         else if (pick < 160) fn = FN_BACKSPACE;
         else if (pick < 192) begin
            fn  = FN_READ;
            idx = pick_read_index();
         end
         else if (pick < 196) fn = FN_UNUSED_A;
         else fn = FN_UNUSED_B;
         repeat (run)
            issue_cmd(fn, 8'($urandom), 8'($urandom), idx, 1'b0, none);
         sent += run;
      end
   endtask

   // ---------------- receiver stalls ----------------

   rx_mode_t    rx_mode    = RX_FREE;
   logic [15:0] stall_bits = 16'hA5C3;
   int unsigned rx_count   = 0;

   always @(posedge clock) begin
      rx_count <= rx_count + 1;
      if (rx_count % 97 == 0) begin
         rx_mode    <= rx_mode_t'($urandom_range(0, 2));
         stall_bits <= 16'($urandom);
      end
      case (rx_mode)
         RX_FREE:    rsp_tready <= 1'b1;
         RX_PATTERN: rsp_tready <= stall_bits[rx_count % 16];
         default:    rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // ---------------- result check ----------------

   function automatic void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      cell_report_t want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none, actual %h",
                     $time, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_reports.pop_front();
            check_field("cursor_position", want.pos, rsp_tdata[10:0]);
            check_field("cell_character", want.ch, rsp_tdata[18:11]);
            check_field("cell_color", want.attr, rsp_tdata[26:19]);
            check_field("scrolled", want.scrolled, rsp_tdata[27]);
         end
      end
   end

   // Cycles with no beat on either stream
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // ---------------- main sequence ----------------

   initial begin : main_seq
      stim_row_t    row;
      cell_report_t typed_want;
      int i;
      fill_color = COLOR_RESET;
      blank_screen();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at the reset color
      for (i = 0; i < N_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         typed_want.pos      = row.want_pos;
         typed_want.ch       = row.want_ch;
         typed_want.attr     = row.want_attr;
         typed_want.scrolled = row.want_scr;
         issue_cmd(row.fn, row.ch, row.attr, row.idx, row.typed, typed_want);
      end

      // Random phases at both color extremes and one arbitrary value
      set_fill_color(8'hFF);
      random_phase(230);
      set_fill_color(8'h00);
      random_phase(230);
      set_fill_color(8'($urandom_range(1, 254)));
      random_phase(240);

      drain_results();
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[files.f]
sv/cts_pkg.sv
sv/cts_ram.sv
sv/cts_ctrl.sv
sv/cts_datapath.sv
sv/text_console_cursor_scroll_top.sv
tb/tb_text_console_cursor_scroll_top.sv
